FILE: rtl/pdsch_coded_bit_count_macros.svh
// Assertion macros for the coded bit count block.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef PDSCH_CODED_BIT_COUNT_MACROS_SVH
`define PDSCH_CODED_BIT_COUNT_MACROS_SVH
`ifndef SYNTHESIS
`define PDSCHCB_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pdschcb implication check failed");
`define PDSCHCB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pdschcb next-cycle check failed");
`else
`define PDSCHCB_ASSERT_IMP(label, clk, rst, ante, cons)
`define PDSCHCB_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/pdschcb_pkg.sv
// Package for the coded bit count block: field widths, constants and codes.
// No dependencies; used by the interfaces and all modules.
`default_nettype none
package pdschcb_pkg;

  localparam int NRB_W   = 7;
  localparam int WORD_W  = 32;
  localparam int WORD3_W = 4;
  localparam int Q_W     = 3;
  localparam int CTRL_W  = 3;
  localparam int SF_W    = 4;
  localparam int CFG_W   = 7;
  localparam int G_W     = 17;

  localparam int MAX_BLOCKS    = 100;
  localparam int BITMAP_BLOCKS = 3 * WORD_W + WORD3_W;
  localparam int USE_W   = (MAX_BLOCKS < BITMAP_BLOCKS) ? MAX_BLOCKS : BITMAP_BLOCKS;
  localparam int WIN_W   = 7;
  localparam int WIN_LO  = 3;
  localparam int HALF_W  = CFG_W - 1;
  localparam int HALF_MAX = (1 << HALF_W) - 1;
  localparam int EXT_W   = (USE_W + WIN_LO > HALF_MAX + WIN_W) ? USE_W + WIN_LO
                                                               : HALF_MAX + WIN_W;
  localparam int N_W     = 4;

  localparam int SYM_W   = 4;
  localparam int PB_W    = 8;
  localparam int NQ_W    = 10;
  localparam int CQ_W    = 10;
  localparam int FAC_W   = 6;
  localparam int PROD_W  = 16;
  localparam int BASE_W  = 18;
  localparam int ADJ_W   = 12;
  localparam int RECIP_W = 16;
  localparam int RECIP_SHIFT = 17;

  localparam logic [SYM_W-1:0]  SYMS_NORMAL = SYM_W'(11);
  localparam logic [SYM_W-1:0]  SYMS_EXT    = SYM_W'(9);
  localparam logic [PB_W-1:0]   RE_PER_SYM  = PB_W'(12);
  localparam logic [PB_W-1:0]   PILOT_TWO   = PB_W'(3 * 8);
  localparam logic [PB_W-1:0]   PILOT_ONE   = PB_W'(3 * 10);
  localparam logic [CQ_W-1:0]   HALF_RE     = CQ_W'(6);
  localparam logic [FAC_W-1:0]  F_TDD_TWO   = FAC_W'(14);
  localparam logic [FAC_W-1:0]  F_TDD_ONE   = FAC_W'(29);
  localparam logic [FAC_W-1:0]  F_FDD_TWO   = FAC_W'(17);
  localparam logic [FAC_W-1:0]  F_FDD_ONE   = FAC_W'(35);
  localparam logic [FAC_W-1:0]  F_SF5_FDD   = FAC_W'(2);
  localparam logic [FAC_W-1:0]  F_SF5_TDD   = FAC_W'(1);
  localparam logic [RECIP_W-1:0] RECIP3     = RECIP_W'(43691);
  localparam logic [ADJ_W-1:0]  ADJ_MAX     = ADJ_W'(3430);
  localparam logic [G_W-1:0]    G_MAX       = G_W'(131071);
  localparam logic [SF_W-1:0]   SF_SYNC0    = SF_W'(0);
  localparam logic [SF_W-1:0]   SF_SYNC5    = SF_W'(5);
  localparam logic [CFG_W-1:0]  DL_BLOCKS_RESET = CFG_W'(25);

  typedef enum logic [1:0] {
    CFG_EXT_PREFIX = 2'd0,
    CFG_DUPLEX_TDD = 2'd1,
    CFG_SINGLE_ANT = 2'd2,
    CFG_DL_BLOCKS  = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    DIV_NONE = 2'd0,
    DIV_3    = 2'd1,
    DIV_6    = 2'd2
  } div_mode_t;

endpackage
`default_nettype wire

FILE: rtl/pdschcb_if.sv
// Handshake interfaces for the allocation request and the coded bit count result.
// Depends on pdschcb_pkg for field widths.
`default_nettype none
interface pdschcb_in_if import pdschcb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [NRB_W-1:0]   alloc_blocks;
  logic [WORD_W-1:0]  alloc_word0;
  logic [WORD_W-1:0]  alloc_word1;
  logic [WORD_W-1:0]  alloc_word2;
  logic [WORD3_W-1:0] alloc_word3;
  logic [Q_W-1:0]     bits_per_symbol;
  logic [CTRL_W-1:0]  control_symbols;
  logic [SF_W-1:0]    subframe_number;

  modport source (output valid, alloc_blocks, alloc_word0, alloc_word1, alloc_word2,
                  alloc_word3, bits_per_symbol, control_symbols, subframe_number,
                  input ready);
  modport sink (input valid, alloc_blocks, alloc_word0, alloc_word1, alloc_word2,
                alloc_word3, bits_per_symbol, control_symbols, subframe_number,
                output ready);
endinterface

interface pdschcb_out_if import pdschcb_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [G_W-1:0] coded_bits;
  logic           underflow;

  modport source (output valid, coded_bits, underflow, input ready);
  modport sink (input valid, coded_bits, underflow, output ready);
endinterface
`default_nettype wire

FILE: rtl/pdschcb_central.sv
// Counts allocated central resource blocks in half-block units of six elements.
// Depends on pdschcb_pkg.
`default_nettype none
module pdschcb_central import pdschcb_pkg::*; (
  input  wire logic [WORD_W-1:0]  word0,
  input  wire logic [WORD_W-1:0]  word1,
  input  wire logic [WORD_W-1:0]  word2,
  input  wire logic [WORD3_W-1:0] word3,
  input  wire logic [CFG_W-1:0]   dl_blocks,
  output logic      [N_W-1:0]     halves
);

  logic [BITMAP_BLOCKS-1:0] map;
  logic [EXT_W-1:0]         ext;
  logic [WIN_W-1:0]         win;
  logic [HALF_W-1:0]        half;
  logic [N_W-1:0]           mid;

  assign map  = {word3, word2, word1, word0};
  assign half = dl_blocks[CFG_W-1:1];

  // The window starts three blocks below the center; zero padding makes
  // negative block indexes read as unallocated.
  always_comb begin
    ext = '0;
    ext[USE_W+WIN_LO-1:WIN_LO] = map[USE_W-1:0];
    win = ext[half +: WIN_W];
    mid = '0;
    for (int i = 1; i < WIN_W - 1; i++) begin
      mid = mid + N_W'(win[i]);
    end
    if (dl_blocks[0]) begin
      halves = N_W'({mid, 1'b0}) + N_W'(win[0]) + N_W'(win[WIN_W-1]);
    end else begin
      halves = N_W'({mid, 1'b0}) + N_W'({win[0], 1'b0});
    end
  end

endmodule
`default_nettype wire

FILE: rtl/pdsch_coded_bit_count.sv
// Coded bit count for a downlink shared channel allocation.
// Each accepted request moves through the registered pipeline stages to rsp.valid;
// one transaction is accepted every cycle while req.ready is high, which a stall can drop.
// Each stage advances when its successor is empty or advancing, so a stall
// holds every item in place. Reset clears all valid bits and loads the
// configuration reset values. Depends on pdschcb_pkg, pdschcb_if, pdschcb_central.
`default_nettype none
`include "pdsch_coded_bit_count_macros.svh"
module pdsch_coded_bit_count import pdschcb_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  pdschcb_in_if.sink            req,
  pdschcb_out_if.source         rsp
);

  logic             extended_prefix;
  logic             duplex_tdd;
  logic             single_antenna;
  logic [CFG_W-1:0] downlink_blocks;

  logic en1, en2, en3, en4, en5;
  logic v1, v2, v3, v4, v5;

  logic [N_W-1:0]   halves;
  logic [SYM_W-1:0] data_syms;
  logic [PB_W-1:0]  per_block_next;

  logic [NRB_W-1:0] nrb1;
  logic [Q_W-1:0]   q1;
  logic [PB_W-1:0]  pb1;
  logic [N_W-1:0]   n1;
  logic             sf0_1, sf5_1;

  logic [NQ_W-1:0]  nq2;
  logic [CQ_W-1:0]  cq2;
  logic [PB_W-1:0]  pb2;
  logic             sf0_2, sf5_2;

  logic [FAC_W-1:0] factor;
  div_mode_t        mode_next;
  logic [BASE_W-1:0] base3;
  logic [PROD_W-1:0] prod3;
  div_mode_t        mode3;
  logic             act3;

  logic [PROD_W+RECIP_W-1:0] recip_prod;
  logic [ADJ_W-1:0]  adj_next;
  logic [BASE_W-1:0] base4;
  logic [ADJ_W-1:0]  adj4;

  logic [BASE_W-1:0] diff;
  logic [G_W-1:0]    coded_bits;
  logic              underflow;

  always_ff @(posedge clk) begin
    if (rst) begin
      extended_prefix <= 1'b0;
      duplex_tdd      <= 1'b0;
      single_antenna  <= 1'b0;
      downlink_blocks <= DL_BLOCKS_RESET;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_EXT_PREFIX: extended_prefix <= cfg_data[0];
        CFG_DUPLEX_TDD: duplex_tdd      <= cfg_data[0];
        CFG_SINGLE_ANT: single_antenna  <= cfg_data[0];
        CFG_DL_BLOCKS:  downlink_blocks <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en5 = !v5 || rsp.ready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign req.ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= req.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  pdschcb_central u_central (
    .word0     (req.alloc_word0),
    .word1     (req.alloc_word1),
    .word2     (req.alloc_word2),
    .word3     (req.alloc_word3),
    .dl_blocks (downlink_blocks),
    .halves    (halves)
  );

  assign data_syms = (extended_prefix ? SYMS_EXT : SYMS_NORMAL) - SYM_W'(req.control_symbols);
  assign per_block_next = PB_W'(data_syms) * RE_PER_SYM
                        + (single_antenna ? PILOT_ONE : PILOT_TWO);

  always_ff @(posedge clk) begin
    if (en1) begin
      nrb1  <= req.alloc_blocks;
      q1    <= req.bits_per_symbol;
      pb1   <= per_block_next;
      n1    <= halves;
      sf0_1 <= req.subframe_number == SF_SYNC0;
      sf5_1 <= req.subframe_number == SF_SYNC5;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      nq2   <= NQ_W'(nrb1) * NQ_W'(q1);
      cq2   <= CQ_W'(n1) * CQ_W'(q1) * HALF_RE;
      pb2   <= pb1;
      sf0_2 <= sf0_1;
      sf5_2 <= sf5_1;
    end
  end

  always_comb begin
    factor    = '0;
    mode_next = DIV_NONE;
    if (sf5_2) begin
      factor = duplex_tdd ? F_SF5_TDD : F_SF5_FDD;
    end else if (sf0_2) begin
      case ({duplex_tdd, single_antenna})
        2'b10:   begin factor = F_TDD_TWO; mode_next = DIV_3; end
        2'b11:   begin factor = F_TDD_ONE; mode_next = DIV_6; end
        2'b00:   begin factor = F_FDD_TWO; mode_next = DIV_3; end
        default: begin factor = F_FDD_ONE; mode_next = DIV_6; end
      endcase
      factor = factor - FAC_W'(extended_prefix);
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      base3 <= BASE_W'(nq2) * BASE_W'(pb2);
      prod3 <= PROD_W'(factor) * PROD_W'(cq2);
      mode3 <= mode_next;
      act3  <= sf0_2 || sf5_2;
    end
  end

  assign recip_prod = (PROD_W+RECIP_W)'(prod3) * (PROD_W+RECIP_W)'(RECIP3);

  always_comb begin
    case (mode3)
      DIV_3:   adj_next = ADJ_W'(recip_prod >> RECIP_SHIFT);
      DIV_6:   adj_next = ADJ_W'(recip_prod >> (RECIP_SHIFT + 1));
      default: adj_next = ADJ_W'(prod3);
    endcase
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      base4 <= base3;
      adj4  <= adj_next;
    end
  end

  assign diff = base4 - BASE_W'(adj4);

  always_ff @(posedge clk) begin
    if (en5) begin
      if (BASE_W'(adj4) > base4) begin
        coded_bits <= '0;
        underflow  <= 1'b1;
      end else begin
        coded_bits <= (diff > BASE_W'(G_MAX)) ? G_MAX : G_W'(diff);
        underflow  <= 1'b0;
      end
    end
  end

  assign rsp.valid      = v5;
  assign rsp.coded_bits = coded_bits;
  assign rsp.underflow  = underflow;

  `PDSCHCB_ASSERT_NEXT(a_stall_holds, clk, rst, v4 && !en4, v4 && $stable(adj4))
  `PDSCHCB_ASSERT_IMP(a_quiet_subframe, clk, rst, v3 && !act3, prod3 == '0)
  `PDSCHCB_ASSERT_IMP(a_adj_bound, clk, rst, v4, adj4 <= ADJ_MAX)
  `PDSCHCB_ASSERT_IMP(a_underflow_zero, clk, rst, v5 && underflow, coded_bits == '0)

endmodule
`default_nettype wire

FILE: tb/tb_pdsch_coded_bit_count.sv
// Self-checking testbench for pdsch_coded_bit_count: drives allocation requests and
// register writes, predicts each coded bit count and compares it field by field.
// Depends on pdschcb_pkg, pdschcb_if and the pdsch_coded_bit_count RTL.
module tb_pdsch_coded_bit_count;
  timeunit 1ns;
  timeprecision 1ps;
  import pdschcb_pkg::*;

  localparam int PHASES = 12;
  localparam int RANDOM_PER_PHASE = 160;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_PCT = 34;

  typedef struct {
    logic [NRB_W-1:0]   alloc_blocks;
    logic [WORD_W-1:0]  word0;
    logic [WORD_W-1:0]  word1;
    logic [WORD_W-1:0]  word2;
    logic [WORD3_W-1:0] word3;
    logic [Q_W-1:0]     bits_per_symbol;
    logic [CTRL_W-1:0]  control_symbols;
    logic [SF_W-1:0]    subframe_number;
  } alloc_t;

  typedef struct {
    logic [G_W-1:0] coded_bits;
    logic           underflow;
  } count_t;

  class coded_bit_scoreboard;
    bit               ext_prefix;
    bit               tdd;
    bit               one_ant;
    logic [CFG_W-1:0] dl_blocks;
    count_t           expected_counts[$];
    int               errors;

    function new();
      ext_prefix = 1'b0;
      tdd = 1'b0;
      one_ant = 1'b0;
      dl_blocks = DL_BLOCKS_RESET;
      errors = 0;
    endfunction

    function void set_register(cfg_index_t idx, logic [CFG_W-1:0] value);
      case (idx)
        CFG_EXT_PREFIX: ext_prefix = value[0];
        CFG_DUPLEX_TDD: tdd = value[0];
        CFG_SINGLE_ANT: one_ant = value[0];
        CFG_DL_BLOCKS:  dl_blocks = value;
        default: ;
      endcase
    endfunction

    // Resource elements of allocated blocks inside the broadcast and sync window.
    function int central_elements(alloc_t a);
      logic [BITMAP_BLOCKS-1:0] map;
      int half, lo, hi, b, re;
      bit odd;
      map = {a.word3, a.word2, a.word1, a.word0};
      odd = dl_blocks[0];
      half = int'(dl_blocks >> 1);
      lo = half - WIN_LO;
      hi = odd ? half + WIN_LO : half + WIN_LO - 1;
      re = 0;
      for (b = lo; b <= hi; b++) begin
        if (b >= 0 && b < BITMAP_BLOCKS && b < MAX_BLOCKS) begin
          if (map[b]) begin
            re += (odd && (b == lo || b == hi)) ? int'(HALF_RE) : int'(RE_PER_SYM);
          end
        end
      end
      return re;
    endfunction

    function count_t predict_coded_bits(alloc_t a);
      int q, syms, per_block, base, c, adj, factor, divisor, g;
      count_t r;
      q = int'(a.bits_per_symbol);
      syms = (ext_prefix ? int'(SYMS_EXT) : int'(SYMS_NORMAL)) - int'(a.control_symbols);
      per_block = syms * int'(RE_PER_SYM) + (one_ant ? int'(PILOT_ONE) : int'(PILOT_TWO));
      base = int'(a.alloc_blocks) * q * per_block;
      adj = 0;
      if (a.subframe_number == SF_SYNC5) begin
        c = central_elements(a);
        adj = (tdd ? int'(F_SF5_TDD) : int'(F_SF5_FDD)) * c * q;
      end else if (a.subframe_number == SF_SYNC0) begin
        c = central_elements(a);
        if (tdd) begin
          factor = one_ant ? int'(F_TDD_ONE) : int'(F_TDD_TWO);
        end else begin
          factor = one_ant ? int'(F_FDD_ONE) : int'(F_FDD_TWO);
        end
        divisor = one_ant ? 6 : 3;
        adj = (factor - int'(ext_prefix)) * c * q / divisor;
      end
      if (adj > base) begin
        r.coded_bits = '0;
        r.underflow = 1'b1;
      end else begin
        g = base - adj;
        if (g > int'(G_MAX)) begin
          g = int'(G_MAX);
        end
        r.coded_bits = G_W'(g);
        r.underflow = 1'b0;
      end
      return r;
    endfunction

    function void note_request(alloc_t a);
      expected_counts.push_back(predict_coded_bits(a));
    endfunction

    function void check_result(logic [G_W-1:0] coded_bits, logic underflow);
      count_t exp_count;
      if (expected_counts.size() == 0) begin
        $error("unexpected result: coded_bits %0d underflow %0d", coded_bits, underflow);
        errors++;
        return;
      end
      exp_count = expected_counts.pop_front();
      if (coded_bits !== exp_count.coded_bits) begin
        $error("coded_bits: expected %0d, actual %0d", exp_count.coded_bits, coded_bits);
        errors++;
      end
      if (underflow !== exp_count.underflow) begin
        $error("underflow: expected %0d, actual %0d", exp_count.underflow, underflow);
        errors++;
      end
    endfunction

    function int pending();
      return expected_counts.size();
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;
  bit               src_steady;
  bit               snk_steady;
  bit               hold_request;
  int               hold_left = 0;

  coded_bit_scoreboard sb = new();

  pdschcb_in_if  req_if();
  pdschcb_out_if rsp_if();

  pdsch_coded_bit_count dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_if),
    .rsp       (rsp_if)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    if (hold_left != 0) begin
      rsp_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left <= HOLD_CYCLES;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= snk_steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : watch
    alloc_t seen;
    if (!rst) begin
      if (req_if.valid && req_if.ready) begin
        seen.alloc_blocks    = req_if.alloc_blocks;
        seen.word0           = req_if.alloc_word0;
        seen.word1           = req_if.alloc_word1;
        seen.word2           = req_if.alloc_word2;
        seen.word3           = req_if.alloc_word3;
        seen.bits_per_symbol = req_if.bits_per_symbol;
        seen.control_symbols = req_if.control_symbols;
        seen.subframe_number = req_if.subframe_number;
        sb.note_request(seen);
      end
      if (rsp_if.valid && rsp_if.ready) begin
        sb.check_result(rsp_if.coded_bits, rsp_if.underflow);
      end
    end
  end

  function automatic alloc_t make_alloc(int nrb, logic [WORD_W-1:0] w0, logic [WORD_W-1:0] w1,
                                        logic [WORD_W-1:0] w2, logic [WORD3_W-1:0] w3,
                                        int q, int ctrl, int sf);
    alloc_t a;
    a.alloc_blocks    = NRB_W'(nrb);
    a.word0           = w0;
    a.word1           = w1;
    a.word2           = w2;
    a.word3           = w3;
    a.bits_per_symbol = Q_W'(q);
    a.control_symbols = CTRL_W'(ctrl);
    a.subframe_number = SF_W'(sf);
    return a;
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) begin
      return '0;
    end else if (pick == 1) begin
      return '1;
    end
    return $urandom;
  endfunction

  function automatic alloc_t rand_alloc();
    alloc_t a;
    int pick;
    pick = $urandom_range(19);
    if (pick < 4) begin
      a.alloc_blocks = NRB_W'($urandom_range(6));
    end else if (pick < 6) begin
      a.alloc_blocks = NRB_W'($urandom_range(127));
    end else begin
      a.alloc_blocks = NRB_W'($urandom_range(100));
    end
    a.word0 = rand_word();
    a.word1 = rand_word();
    a.word2 = rand_word();
    a.word3 = WORD3_W'($urandom_range(15));
    if ($urandom_range(7) == 0) begin
      a.bits_per_symbol = Q_W'($urandom_range(7));
    end else begin
      a.bits_per_symbol = Q_W'(2 * $urandom_range(3, 1));
    end
    if ($urandom_range(7) == 0) begin
      a.control_symbols = CTRL_W'($urandom_range(7));
    end else begin
      a.control_symbols = CTRL_W'($urandom_range(4));
    end
    pick = $urandom_range(9);
    if (pick < 4) begin
      a.subframe_number = SF_SYNC0;
    end else if (pick < 7) begin
      a.subframe_number = SF_SYNC5;
    end else if (pick == 7) begin
      a.subframe_number = SF_W'($urandom_range(15));
    end else begin
      a.subframe_number = SF_W'($urandom_range(9));
    end
    return a;
  endfunction

  task automatic send_alloc(alloc_t a);
    if (!src_steady) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        @(negedge clk);
        req_if.valid <= 1'b0;
      end
    end
    @(negedge clk);
    req_if.valid           <= 1'b1;
    req_if.alloc_blocks    <= a.alloc_blocks;
    req_if.alloc_word0     <= a.word0;
    req_if.alloc_word1     <= a.word1;
    req_if.alloc_word2     <= a.word2;
    req_if.alloc_word3     <= a.word3;
    req_if.bits_per_symbol <= a.bits_per_symbol;
    req_if.control_symbols <= a.control_symbols;
    req_if.subframe_number <= a.subframe_number;
    @(posedge clk);
    while (!req_if.ready) begin
      @(posedge clk);
    end
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_register(idx, value);
  endtask

  task automatic apply_setting(bit ext, bit tdd, bit one, logic [CFG_W-1:0] dl);
    write_reg(CFG_EXT_PREFIX, CFG_W'(ext));
    write_reg(CFG_DUPLEX_TDD, CFG_W'(tdd));
    write_reg(CFG_SINGLE_ANT, CFG_W'(one));
    write_reg(CFG_DL_BLOCKS, dl);
  endtask

  task automatic drain();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin : stimulus
    int phase;
    logic [CFG_W-1:0] dl;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_EXT_PREFIX;
    cfg_data = '0;
    req_if.valid = 1'b0;
    req_if.alloc_blocks = '0;
    req_if.alloc_word0 = '0;
    req_if.alloc_word1 = '0;
    req_if.alloc_word2 = '0;
    req_if.alloc_word3 = '0;
    req_if.bits_per_symbol = '0;
    req_if.control_symbols = '0;
    req_if.subframe_number = '0;
    rsp_if.ready = 1'b0;
    src_steady = 1'b0;
    snk_steady = 1'b0;
    hold_request = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: apply_setting(1'b0, 1'b0, 1'b0, DL_BLOCKS_RESET);
        1: apply_setting(1'b0, 1'b0, 1'b0, CFG_W'(6));
        2: apply_setting(1'b1, 1'b1, 1'b1, CFG_W'(100));
        3: apply_setting(1'b0, 1'b1, 1'b0, CFG_W'(127));
        4: apply_setting(1'b1, 1'b0, 1'b1, CFG_W'(0));
        5: apply_setting(1'b0, 1'b0, 1'b1, CFG_W'(7));
        6: apply_setting(1'b1, 1'b1, 1'b0, CFG_W'(3));
        default: begin
          dl = ($urandom_range(3) == 0) ? CFG_W'($urandom_range(127))
                                        : CFG_W'($urandom_range(100, 6));
          apply_setting(1'($urandom_range(1)), 1'($urandom_range(1)),
                        1'($urandom_range(1)), dl);
        end
      endcase
      src_steady = (phase == 1 || phase == 2);
      snk_steady = (phase == 1);
      if (phase == 2) begin
        hold_request = 1'b1;
      end

      if (phase == 0) begin
        send_alloc(make_alloc(0, '0, '0, '0, '0, 2, 0, 1));
        send_alloc(make_alloc(100, '1, '1, '1, '1, 6, 0, 0));
        send_alloc(make_alloc(100, '1, '1, '1, '1, 6, 4, 5));
        send_alloc(make_alloc(127, '1, '1, '1, '1, 7, 0, 1));
        send_alloc(make_alloc(1, '1, '1, '1, '1, 2, 0, 0));
        send_alloc(make_alloc(0, '1, '1, '1, '1, 4, 3, 5));
        send_alloc(make_alloc(50, '1, '1, '1, '1, 0, 2, 0));
        send_alloc(make_alloc(20, '1, '1, '1, '1, 1, 5, 0));
        send_alloc(make_alloc(20, '1, '1, '1, '1, 3, 6, 5));
        send_alloc(make_alloc(20, '1, '1, '1, '1, 5, 7, 0));
        send_alloc(make_alloc(64, '1, '1, '1, '1, 4, 1, 10));
        send_alloc(make_alloc(64, '1, '1, '1, '1, 4, 2, 15));
        send_alloc(make_alloc(64, '1, '1, '1, '1, 6, 3, 9));
        send_alloc(make_alloc(30, 32'h0000_8200, '0, '0, '0, 4, 1, 0));
        send_alloc(make_alloc(30, 32'h0000_7C00, '0, '0, '0, 4, 1, 5));
        send_alloc(make_alloc(100, '0, '0, '0, 4'hF, 2, 0, 0));
        send_alloc(make_alloc(100, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 4'h5,
                              6, 2, 0));
        send_alloc(make_alloc(100, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 4'hA,
                              2, 3, 5));
        send_alloc(make_alloc(6, '1, '1, '1, '1, 6, 4, 0));
        send_alloc(make_alloc(7, 32'h0000_FE00, '0, '0, '0, 2, 1, 0));
        send_alloc(make_alloc(99, '1, '1, '1, '1, 4, 0, 2));
        send_alloc(make_alloc(100, '1, '1, '1, '1, 6, 7, 0));
      end

      repeat (RANDOM_PER_PHASE) begin
        send_alloc(rand_alloc());
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
